// ===== src/sblp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sblp_pkg
// Shared types and constants for the SSH banner line parser.
// ----------------------------------------------------------------------------
package sblp_pkg;

    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 10;
    localparam int KIND_W  = 2;
    localparam int PHASE_W = 2;
    localparam int POS_W   = 3;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    localparam logic [LEN_W-1:0] LEN_SAT         = 10'd1023;
    localparam logic [LEN_W-1:0] MAX_LEN_RESET   = 10'd255;
    localparam logic [LEN_W-1:0] PREFIX_LEN      = 10'd4;
    localparam logic [POS_W-1:0] PREFIX_POS_LAST = 3'd4;

    localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_DASH  = 8'h2D;
    localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;

    // Identification prefix "SSH-".
    localparam logic [BYTE_W-1:0] SIG [4] = '{8'h53, 8'h53, 8'h48, 8'h2D};

    localparam logic [KIND_W-1:0] KIND_BANNER   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NO_DASH  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TOO_LONG = 2'd2;
    localparam logic [KIND_W-1:0] KIND_REST     = 2'd3;

    localparam logic [PHASE_W-1:0] PHASE_VERSION  = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_SOFTWARE = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_COMMENTS = 2'd2;

    // Register index of max_line_len, taken from paddr[2].
    localparam logic REG_MAX_LINE_LEN = 1'b0;

    typedef enum logic [1:0] {
        MODE_SEARCH = 2'd0,
        MODE_PASS   = 2'd1,
        MODE_HALT   = 2'd2
    } t_mode;

    // One received byte with its classification, carried from front to back.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              is_lf;
        logic              is_cr;
        logic              is_dash;
        logic              is_space;
        logic              sig_miss;
    } t_byte_class;

endpackage

// ===== src/sblp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sblp_front
// Accepts received bytes and classifies them, including the prefix check.
// ----------------------------------------------------------------------------
module sblp_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [7:0]           i_in_byte,
    input  logic                 i_q_full,
    output logic                 o_ready,
    output logic                 o_push,
    output sblp_pkg::t_byte_class o_class
);
    import sblp_pkg::*;

    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic             accept;
    logic             in_prefix;

    assign o_ready   = !i_q_full;
    assign accept    = i_valid && o_ready;
    assign o_push    = accept;
    assign in_prefix = (r_pos != PREFIX_POS_LAST);

    always_comb begin
        o_class.data     = i_in_byte;
        o_class.is_lf    = (i_in_byte == CHAR_LF);
        o_class.is_cr    = (i_in_byte == CHAR_CR);
        o_class.is_dash  = (i_in_byte == CHAR_DASH);
        o_class.is_space = (i_in_byte == CHAR_SPACE);
        o_class.sig_miss = in_prefix && (i_in_byte != SIG[r_pos[1:0]]);
    end

    // Position within the current line, held at four once the prefix is past.
    always_comb begin
        n_pos = r_pos;
        if (accept) begin
            if (i_in_byte == CHAR_LF) begin
                n_pos = '0;
            end else if (in_prefix) begin
                n_pos = r_pos + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

endmodule

// ===== src/sblp_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sblp_queue
// Two-entry queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
module sblp_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  sblp_pkg::t_byte_class i_class,
    input  logic                  i_pop,
    output logic                  o_full,
    output logic                  o_empty,
    output sblp_pkg::t_byte_class o_class
);
    import sblp_pkg::*;

    t_byte_class r_mem [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;
    logic        do_push;
    logic        do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_class = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_class;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== src/sblp_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sblp_back
// Line and field counting, banner result and rest-byte pass-through, with
// the output register.
// ----------------------------------------------------------------------------
module sblp_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_empty,
    input  sblp_pkg::t_byte_class i_class,
    input  logic [9:0]            i_max_line_len,
    input  logic                  i_out_ready,
    output logic                  o_pop,
    output logic                  o_valid,
    output logic [1:0]            o_out_kind,
    output logic [9:0]            o_version_len,
    output logic [9:0]            o_software_len,
    output logic [9:0]            o_comments_len,
    output logic                  o_has_comments,
    output logic [9:0]            o_line_len,
    output logic [7:0]            o_rest_byte
);
    import sblp_pkg::*;

    t_mode              r_mode, n_mode;
    logic [LEN_W-1:0]   r_line_count, n_line_count;
    logic               r_line_over, n_line_over;
    logic               r_prefix_ok, n_prefix_ok;
    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [LEN_W-1:0]   r_ver, n_ver;
    logic [LEN_W-1:0]   r_soft, n_soft;
    logic [LEN_W-1:0]   r_comm, n_comm;
    logic [LEN_W-1:0]   r_pending, n_pending;
    logic               r_space, n_space;

    logic               r_out_valid;
    logic [KIND_W-1:0]  r_kind;
    logic [LEN_W-1:0]   r_ver_len, r_soft_len, r_comm_len, r_line_len;
    logic               r_has_comm;
    logic [BYTE_W-1:0]  r_rest;

    logic               res_valid;
    logic [KIND_W-1:0]  res_kind;
    logic [LEN_W-1:0]   res_ver, res_soft, res_comm, res_line;
    logic               res_has_comm;
    logic [BYTE_W-1:0]  res_rest;

    logic               full;
    logic [LEN_W-1:0]   total;
    logic               is_banner;
    logic               too_long;
    logic               at_lf;
    logic [LEN_W-1:0]   field_base;
    logic               add_one;
    logic [LEN_W+1:0]   field_sum;
    logic [LEN_W-1:0]   field_sat;

    // A new request is taken whenever the output slot is free or being drained.
    assign o_pop = !i_q_empty && (!r_out_valid || i_out_ready);
    assign at_lf = o_pop && (r_mode == MODE_SEARCH) && i_class.is_lf;

    assign full      = r_line_over || (r_line_count == LEN_SAT);
    assign total     = full ? LEN_SAT : (r_line_count + 10'd1);
    assign is_banner = r_prefix_ok && (r_line_count >= PREFIX_LEN);
    assign too_long  = full || (total > i_max_line_len);

    always_comb begin
        case (r_phase)
            PHASE_VERSION:  field_base = r_ver;
            PHASE_SOFTWARE: field_base = r_soft;
            default:        field_base = r_comm;
        endcase
    end

    // Pending CR bytes and the byte, unless it ends the field, land in one add.
    assign add_one = !((r_phase == PHASE_VERSION) && i_class.is_dash) &&
                     !((r_phase == PHASE_SOFTWARE) && i_class.is_space);
    assign field_sum = {2'b00, field_base} + {2'b00, r_pending} + {11'd0, add_one};
    assign field_sat = (field_sum > {2'b00, LEN_SAT}) ? LEN_SAT : field_sum[LEN_W-1:0];

    // Next mode.
    always_comb begin
        n_mode = r_mode;
        if (at_lf && is_banner) begin
            if (too_long || (r_phase == PHASE_VERSION)) begin
                n_mode = MODE_HALT;
            end else begin
                n_mode = MODE_PASS;
            end
        end
    end

    // Line datapath and result.
    always_comb begin
        n_line_count = r_line_count;
        n_line_over  = r_line_over;
        n_prefix_ok  = r_prefix_ok;
        n_phase      = r_phase;
        n_ver        = r_ver;
        n_soft       = r_soft;
        n_comm       = r_comm;
        n_pending    = r_pending;
        n_space      = r_space;
        res_valid    = 1'b0;
        res_kind     = KIND_BANNER;
        res_ver      = '0;
        res_soft     = '0;
        res_comm     = '0;
        res_line     = '0;
        res_has_comm = 1'b0;
        res_rest     = '0;
        if (o_pop) begin
            case (r_mode)
                MODE_PASS: begin
                    res_valid = 1'b1;
                    res_kind  = KIND_REST;
                    res_rest  = i_class.data;
                end
                MODE_SEARCH: begin
                    if (i_class.is_lf) begin
                        if (is_banner) begin
                            res_valid = 1'b1;
                            res_line  = total;
                            if (too_long) begin
                                res_kind = KIND_TOO_LONG;
                            end else if (r_phase == PHASE_VERSION) begin
                                res_kind = KIND_NO_DASH;
                            end else begin
                                res_kind     = KIND_BANNER;
                                res_ver      = r_ver;
                                res_soft     = r_soft;
                                res_comm     = r_comm;
                                res_has_comm = r_space;
                            end
                        end
                        n_line_count = '0;
                        n_line_over  = 1'b0;
                        n_prefix_ok  = 1'b1;
                        n_phase      = PHASE_VERSION;
                        n_ver        = '0;
                        n_soft       = '0;
                        n_comm       = '0;
                        n_pending    = '0;
                        n_space      = 1'b0;
                    end else begin
                        if (r_line_count < PREFIX_LEN) begin
                            if (i_class.sig_miss) begin
                                n_prefix_ok = 1'b0;
                            end
                        end else if (i_class.is_cr) begin
                            n_pending = (r_pending == LEN_SAT) ? LEN_SAT
                                                               : (r_pending + 10'd1);
                        end else begin
                            n_pending = '0;
                            case (r_phase)
                                PHASE_VERSION:  n_ver  = field_sat;
                                PHASE_SOFTWARE: n_soft = field_sat;
                                default:        n_comm = field_sat;
                            endcase
                            if ((r_phase == PHASE_VERSION) && i_class.is_dash) begin
                                n_phase = PHASE_SOFTWARE;
                            end else if ((r_phase == PHASE_SOFTWARE) &&
                                         i_class.is_space) begin
                                n_phase = PHASE_COMMENTS;
                                n_space = 1'b1;
                            end
                        end
                        if (r_line_count == LEN_SAT) begin
                            n_line_over = 1'b1;
                        end else begin
                            n_line_count = r_line_count + 10'd1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_SEARCH;
            r_line_count <= '0;
            r_line_over  <= 1'b0;
            r_prefix_ok  <= 1'b1;
            r_phase      <= PHASE_VERSION;
            r_ver        <= '0;
            r_soft       <= '0;
            r_comm       <= '0;
            r_pending    <= '0;
            r_space      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_mode       <= n_mode;
            r_line_count <= n_line_count;
            r_line_over  <= n_line_over;
            r_prefix_ok  <= n_prefix_ok;
            r_phase      <= n_phase;
            r_ver        <= n_ver;
            r_soft       <= n_soft;
            r_comm       <= n_comm;
            r_pending    <= n_pending;
            r_space      <= n_space;
            if (o_pop) begin
                r_out_valid <= res_valid;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && res_valid) begin
            r_kind     <= res_kind;
            r_ver_len  <= res_ver;
            r_soft_len <= res_soft;
            r_comm_len <= res_comm;
            r_line_len <= res_line;
            r_has_comm <= res_has_comm;
            r_rest     <= res_rest;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_out_kind     = r_kind;
    assign o_version_len  = r_ver_len;
    assign o_software_len = r_soft_len;
    assign o_comments_len = r_comm_len;
    assign o_has_comments = r_has_comm;
    assign o_line_len     = r_line_len;
    assign o_rest_byte    = r_rest;

endmodule

// ===== src/ssh_banner_line_parser_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssh_banner_line_parser_unit
// Splits received bytes into lines, parses the first SSH identification line
// into field lengths and, if it is well formed, passes later bytes through.
// ----------------------------------------------------------------------------
//  Channel   Signals                              Direction
//  input     i_valid / o_ready, i_in_byte          in
//  result    o_valid / i_ready, o_out_kind ...     out
//  config    psel penable pwrite paddr pwdata      APB, max_line_len at 0x0
//
// One byte is accepted per cycle while the queue is not full; a result is
// valid only after its byte has landed in the queue at the edge that accepts
// it and the back stage has then loaded the output register from the queue.
// The two-entry queue lets the front keep taking bytes while the output
// register waits on i_ready. Reset is synchronous and clears all control
// state; max_line_len returns to 255.
// ----------------------------------------------------------------------------
module ssh_banner_line_parser_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_in_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_out_kind,
    output logic [9:0]  o_version_len,
    output logic [9:0]  o_software_len,
    output logic [9:0]  o_comments_len,
    output logic        o_has_comments,
    output logic [9:0]  o_line_len,
    output logic [7:0]  o_rest_byte,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sblp_pkg::*;

    logic [LEN_W-1:0] r_max_line_len;
    logic             reg_hit;
    logic             q_full;
    logic             q_empty;
    logic             push;
    logic             pop;
    t_byte_class      front_class;
    t_byte_class      q_class;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == REG_MAX_LINE_LEN);
    assign prdata  = reg_hit ? {{(DATA_W-LEN_W){1'b0}}, r_max_line_len} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_line_len <= MAX_LEN_RESET;
        end else if (psel && penable && pwrite && reg_hit) begin
            r_max_line_len <= pwdata[LEN_W-1:0];
        end
    end

    sblp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_in_byte (i_in_byte),
        .i_q_full  (q_full),
        .o_ready   (o_ready),
        .o_push    (push),
        .o_class   (front_class)
    );

    sblp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_class (front_class),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_class (q_class)
    );

    sblp_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_class        (q_class),
        .i_max_line_len (r_max_line_len),
        .i_out_ready    (i_ready),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .o_out_kind     (o_out_kind),
        .o_version_len  (o_version_len),
        .o_software_len (o_software_len),
        .o_comments_len (o_comments_len),
        .o_has_comments (o_has_comments),
        .o_line_len     (o_line_len),
        .o_rest_byte    (o_rest_byte)
    );

endmodule
